// ===== hdl/eta_phi_image_binner_assert.svh =====
// ----------------------------------------------------------------------------
// eta_phi_image_binner assertion macros
// shared concurrent assertion forms for the image binner
// ----------------------------------------------------------------------------
`ifndef ETA_PHI_IMAGE_BINNER_ASSERT_SVH
`define ETA_PHI_IMAGE_BINNER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define EPIB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define EPIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/epib_pkg.sv =====
// ----------------------------------------------------------------------------
// epib_pkg
// types, register indexes and saturating arithmetic of the eta-phi binner
// ----------------------------------------------------------------------------
package epib_pkg;

  localparam int COORD_W    = 16;
  localparam int VAL_W      = 24;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int BIN_IDX_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int BIN_SHIFT  = 20;
  localparam int BIN_FULL_W = PROD_W - BIN_SHIFT;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TRACK = 2'd1,
    OP_TOWER = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_ETA_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  typedef struct packed {
    op_t                        op;
    logic signed [COORD_W-1:0]  eta;
    logic signed [COORD_W-1:0]  phi;
    logic [VAL_W-1:0]           track_pt;
    logic [VAL_W-1:0]           em_energy;
    logic [VAL_W-1:0]           had_energy;
    logic [BIN_IDX_W-1:0]       bin_index;
  } in_item_t;

  // result item, also the layout of one stored bin
  typedef struct packed {
    logic [SUM_W-1:0] track_sum;
    logic [SUM_W-1:0] em_sum;
    logic [SUM_W-1:0] had_sum;
    logic [CNT_W-1:0] track_count;
    logic [CNT_W-1:0] em_count;
    logic [CNT_W-1:0] had_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] eta_low;
    logic [COORD_W-1:0]        eta_scale;
    logic signed [COORD_W-1:0] phi_low;
    logic [COORD_W-1:0]        phi_scale;
    logic [VAL_W-1:0]          count_threshold;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    eta_low:         16'hD000,
    eta_scale:       16'd2731,
    phi_low:         16'hCDBC,
    phi_scale:       16'd2608,
    count_threshold: 24'd0
  };

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [VAL_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {{(SUM_W + 1 - VAL_W){1'b0}}, v};
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// ===== hdl/epib_ram.sv =====
// ----------------------------------------------------------------------------
// epib_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module epib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/epib_locate.sv =====
// ----------------------------------------------------------------------------
// epib_locate
// coordinate to bin mapping: registered scale products, then range check
// and flat bin index
// ----------------------------------------------------------------------------
module epib_locate #(
  parameter int ETA_BINS = 64,
  parameter int PHI_BINS = 64
) (
  input  logic                                      clk,
  input  logic                                      load,
  input  logic signed [epib_pkg::COORD_W-1:0]       eta,
  input  logic signed [epib_pkg::COORD_W-1:0]       phi,
  input  epib_pkg::cfg_regs_t                       cfg,
  output logic                                      hit,
  output logic [$clog2(ETA_BINS*PHI_BINS)-1:0]      index
);

  localparam int AW  = $clog2(ETA_BINS * PHI_BINS);
  localparam int EBW = $clog2(ETA_BINS);
  localparam int PBW = $clog2(PHI_BINS);
  localparam int DW  = epib_pkg::DIFF_W;
  localparam int PW  = epib_pkg::PROD_W;
  localparam int BFW = epib_pkg::BIN_FULL_W;
  localparam logic [AW-1:0] ETA_STRIDE = AW'(ETA_BINS);

  logic signed [DW-1:0] d_eta;
  logic signed [DW-1:0] d_phi;
  logic signed [PW-1:0] p_eta;
  logic signed [PW-1:0] p_phi;
  logic [BFW-1:0]       eb_full;
  logic [BFW-1:0]       pb_full;
  logic                 eta_ok;
  logic                 phi_ok;

  // offset from the grid edge, one extra bit
  assign d_eta = $signed({eta[epib_pkg::COORD_W-1], eta})
               - $signed({cfg.eta_low[epib_pkg::COORD_W-1], cfg.eta_low});
  assign d_phi = $signed({phi[epib_pkg::COORD_W-1], phi})
               - $signed({cfg.phi_low[epib_pkg::COORD_W-1], cfg.phi_low});

  always_ff @(posedge clk) begin
    if (load) begin
      p_eta <= d_eta * $signed({1'b0, cfg.eta_scale});
      p_phi <= d_phi * $signed({1'b0, cfg.phi_scale});
    end
  end

  // floor of the q.20 product
  assign eb_full = p_eta[PW-1:epib_pkg::BIN_SHIFT];
  assign pb_full = p_phi[PW-1:epib_pkg::BIN_SHIFT];
  assign eta_ok  = !p_eta[PW-1] && (eb_full < BFW'(ETA_BINS));
  assign phi_ok  = !p_phi[PW-1] && (pb_full < BFW'(PHI_BINS));

  assign hit   = eta_ok && phi_ok;
  assign index = AW'(eb_full[EBW-1:0]) + AW'(pb_full[PBW-1:0]) * ETA_STRIDE;

endmodule

// ===== hdl/eta_phi_image_binner.sv =====
// ----------------------------------------------------------------------------
// eta_phi_image_binner
// six eta-phi images (track, em, hadronic sums and counts) kept in one ram
// word per bin, filled by read-modify-write and read back one bin at a time
// ----------------------------------------------------------------------------
// One transaction at a time: a track fill, tower fill or bin read runs from
// acceptance through capture, scale multiply, bin index and ram read, then
// update or result load; the last step holds on a read while the previous
// result still waits on the output. A clear writes one bin word per cycle
// through the ram write port until every bin is zero, and after reset the
// same sweep runs with in_ready low; configuration writes are taken at any
// time. Coordinates outside the grid leave every bin unchanged, sums
// saturate at 0xFFFFFFFF and counts at 0xFFFF, and a read of an index past
// the grid returns all zeros.
// ----------------------------------------------------------------------------
`include "eta_phi_image_binner_assert.svh"

module eta_phi_image_binner #(
  parameter int ETA_BINS = 64,
  parameter int PHI_BINS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  epib_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output epib_pkg::out_item_t                 out_data,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [epib_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [epib_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NBINS = ETA_BINS * PHI_BINS;
  localparam int AW    = $clog2(NBINS);
  localparam int WW    = $bits(epib_pkg::out_item_t);
  localparam logic [AW-1:0] LAST_BIN = AW'(NBINS - 1);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MUL   = 5'b00100,
    S_ADDR  = 5'b01000,
    S_UPD   = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  epib_pkg::cfg_regs_t  cfg;
  epib_pkg::in_item_t   item;
  logic [AW-1:0]        clr_addr;
  logic [AW-1:0]        addr;
  logic                 hit;

  logic                 loc_hit;
  logic [AW-1:0]        loc_index;
  logic                 rd_hit;
  logic [AW-1:0]        lookup_addr;
  logic                 lookup_hit;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  epib_pkg::out_item_t  ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WW-1:0]        ram_rdata;
  epib_pkg::out_item_t  bin_word;
  epib_pkg::out_item_t  bin_new;

  logic                 in_fire;
  logic                 out_free;
  logic                 is_read;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign is_read   = (item.op == epib_pkg::OP_READ);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= epib_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        epib_pkg::REG_ETA_LOW:   cfg.eta_low         <= cfg_data[epib_pkg::COORD_W-1:0];
        epib_pkg::REG_ETA_SCALE: cfg.eta_scale       <= cfg_data[epib_pkg::COORD_W-1:0];
        epib_pkg::REG_PHI_LOW:   cfg.phi_low         <= cfg_data[epib_pkg::COORD_W-1:0];
        epib_pkg::REG_PHI_SCALE: cfg.phi_scale       <= cfg_data[epib_pkg::COORD_W-1:0];
        epib_pkg::REG_THRESHOLD: cfg.count_threshold <= cfg_data[epib_pkg::VAL_W-1:0];
        default: begin
          // index past the register list: no effect
        end
      endcase
    end
  end

  // ------------------------------------------------------------ bin location
  epib_locate #(
    .ETA_BINS (ETA_BINS),
    .PHI_BINS (PHI_BINS)
  ) u_locate (
    .clk   (clk),
    .load  (state == S_MUL),
    .eta   (item.eta),
    .phi   (item.phi),
    .cfg   (cfg),
    .hit   (loc_hit),
    .index (loc_index)
  );

  // a read past the grid still answers, with zeros
  assign rd_hit      = 32'(item.bin_index) < 32'(NBINS);
  assign lookup_hit  = is_read ? rd_hit : loc_hit;
  assign lookup_addr = is_read ? (rd_hit ? AW'(item.bin_index) : '0) : loc_index;

  // ---------------------------------------------------------------- bin ram
  // read address is held through the update step so a stalled read keeps data
  assign ram_raddr = (state == S_ADDR) ? lookup_addr : addr;

  epib_ram #(
    .WIDTH (WW),
    .DEPTH (NBINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign bin_word = epib_pkg::out_item_t'(ram_rdata);

  // modify step of the read-modify-write
  always_comb begin
    bin_new = bin_word;
    unique case (item.op)
      epib_pkg::OP_TRACK: begin
        bin_new.track_sum   = epib_pkg::sat_add(bin_word.track_sum, item.track_pt);
        bin_new.track_count = epib_pkg::cnt_inc(bin_word.track_count);
      end
      epib_pkg::OP_TOWER: begin
        bin_new.em_sum  = epib_pkg::sat_add(bin_word.em_sum, item.em_energy);
        bin_new.had_sum = epib_pkg::sat_add(bin_word.had_sum, item.had_energy);
        if (item.em_energy > cfg.count_threshold) begin
          bin_new.em_count = epib_pkg::cnt_inc(bin_word.em_count);
        end
        if (item.had_energy > cfg.count_threshold) begin
          bin_new.had_count = epib_pkg::cnt_inc(bin_word.had_count);
        end
      end
      default: begin
        // clear and read leave the word as is
      end
    endcase
  end

  // clear sweep writes zeros, a fill that landed on the grid writes back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = bin_new;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_UPD && hit &&
                 (item.op == epib_pkg::OP_TRACK || item.op == epib_pkg::OP_TOWER)) begin
      ram_we = 1'b1;
    end
  end

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_BIN) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_data.op == epib_pkg::OP_CLEAR) ? S_CLEAR : S_MUL;
        end
      end
      S_MUL:  state_next = S_ADDR;
      S_ADDR: state_next = S_UPD;
      S_UPD: begin
        if (!is_read || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        clr_addr <= '0;
      end else if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // transaction payload and lookup result, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
    if (state == S_ADDR) begin
      addr <= lookup_addr;
      hit  <= lookup_hit;
    end
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_UPD && is_read && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD && is_read && out_free) begin
      out_data <= hit ? bin_word : '0;
    end
  end

  // ------------------------------------------------------------- assertions
  // the ram is written only by the clear sweep or an update step
  `EPIB_ASSERT_SAME(a_write_source, ram_we, (state == S_CLEAR || state == S_UPD), "ram write outside clear or update")
  // the clear sweep only ever writes zero words
  `EPIB_ASSERT_SAME(a_clear_zero, state == S_CLEAR, (ram_we && ram_wdata == '0), "clear sweep wrote a nonzero word")
  // an accepted transaction takes the block out of idle
  `EPIB_ASSERT_NEXT(a_leave_idle, in_fire, state != S_IDLE, "accepted transaction left the block idle")
  // a read that finds the output free presents a result next cycle
  `EPIB_ASSERT_NEXT(a_read_result, (state == S_UPD && is_read && out_free), out_valid, "read finished without a result")

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the eta-phi image binner: directed edge cases, random fills and bin
// reads under several grid settings, saturation runs and back pressure. Each
// read result is compared against a bench-side copy of the six images.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ETA_BINS        = 64;
  localparam int PHI_BINS        = 64;
  localparam int NUM_BINS        = ETA_BINS * PHI_BINS;
  // a clear sweeps every bin, so wait out one full sweep before touching registers
  localparam int CLEAR_PAUSE     = NUM_BINS + 100;
  localparam int STALL_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 300;
  localparam int SAT_FILLS       = 270;
  localparam int HOT_SPOTS       = 8;
  localparam int REG_COUNT       = 5;
  localparam longint SUM_LIMIT   = 64'h0000_0000_FFFF_FFFF;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  epib_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  epib_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [epib_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [epib_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // bench copy of the registers and of the six images, one word per bin
  epib_pkg::cfg_regs_t   grid_cfg = epib_pkg::CFG_RESET;
  epib_pkg::out_item_t   bin_image [NUM_BINS];
  epib_pkg::out_item_t   pending_reads [$];

  int error_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // coordinates that random traffic keeps hitting, so bins build up
  logic signed [epib_pkg::COORD_W-1:0] hot_eta [HOT_SPOTS];
  logic signed [epib_pkg::COORD_W-1:0] hot_phi [HOT_SPOTS];

  eta_phi_image_binner #(
    .ETA_BINS(ETA_BINS),
    .PHI_BINS(PHI_BINS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // image prediction
  // --------------------------------------------------------------------------

  function automatic void clear_image();
    foreach (bin_image[i]) bin_image[i] = '0;
  endfunction

  // floor((coord - low) * scale) with the product in Q.20, false when off grid
  function automatic bit axis_bin(input logic signed [epib_pkg::COORD_W-1:0] coord,
                                  input logic signed [epib_pkg::COORD_W-1:0] low,
                                  input logic [epib_pkg::COORD_W-1:0] scale,
                                  input int nbins, output int bin);
    longint diff;
    longint prod;
    diff = longint'(coord) - longint'(low);
    prod = diff * longint'(scale);
    if (prod < 0) return 1'b0;
    if ((prod >>> 20) >= nbins) return 1'b0;
    bin = int'(prod >>> 20);
    return 1'b1;
  endfunction

  function automatic bit locate_bin(input logic signed [epib_pkg::COORD_W-1:0] eta,
                                    input logic signed [epib_pkg::COORD_W-1:0] phi,
                                    output int idx);
    int eb;
    int pb;
    if (!axis_bin(eta, grid_cfg.eta_low, grid_cfg.eta_scale, ETA_BINS, eb)) return 1'b0;
    if (!axis_bin(phi, grid_cfg.phi_low, grid_cfg.phi_scale, PHI_BINS, pb)) return 1'b0;
    idx = eb + pb * ETA_BINS;
    return 1'b1;
  endfunction

  function automatic logic [epib_pkg::SUM_W-1:0] add_saturating(
      input logic [epib_pkg::SUM_W-1:0] s, input logic [epib_pkg::VAL_W-1:0] v);
    longint total;
    total = longint'(s) + longint'(v);
    return (total > SUM_LIMIT) ? {epib_pkg::SUM_W{1'b1}} : total[epib_pkg::SUM_W-1:0];
  endfunction

  function automatic logic [epib_pkg::CNT_W-1:0] bump_count(
      input logic [epib_pkg::CNT_W-1:0] c);
    return c + epib_pkg::CNT_W'(c != {epib_pkg::CNT_W{1'b1}});
  endfunction

  // update the images for one accepted transaction, queue the answer of a read
  function automatic void predict_item(input epib_pkg::in_item_t it);
    int idx;
    case (it.op)
      epib_pkg::OP_CLEAR: begin
        clear_image();
      end
      epib_pkg::OP_TRACK: begin
        if (locate_bin(it.eta, it.phi, idx)) begin
          bin_image[idx].track_sum   = add_saturating(bin_image[idx].track_sum, it.track_pt);
          bin_image[idx].track_count = bump_count(bin_image[idx].track_count);
        end
      end
      epib_pkg::OP_TOWER: begin
        if (locate_bin(it.eta, it.phi, idx)) begin
          bin_image[idx].em_sum  = add_saturating(bin_image[idx].em_sum, it.em_energy);
          bin_image[idx].had_sum = add_saturating(bin_image[idx].had_sum, it.had_energy);
          // zero energy still adds, counting needs strictly above threshold
          if (it.em_energy > grid_cfg.count_threshold) begin
            bin_image[idx].em_count = bump_count(bin_image[idx].em_count);
          end
          if (it.had_energy > grid_cfg.count_threshold) begin
            bin_image[idx].had_count = bump_count(bin_image[idx].had_count);
          end
        end
      end
      default: begin
        if (it.bin_index < NUM_BINS) begin
          pending_reads.push_back(bin_image[it.bin_index]);
        end else begin
          pending_reads.push_back('0);
        end
      end
    endcase
  endfunction

  function automatic void update_regs(input logic [epib_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [epib_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      epib_pkg::REG_ETA_LOW:   grid_cfg.eta_low         = data[epib_pkg::COORD_W-1:0];
      epib_pkg::REG_ETA_SCALE: grid_cfg.eta_scale       = data[epib_pkg::COORD_W-1:0];
      epib_pkg::REG_PHI_LOW:   grid_cfg.phi_low         = data[epib_pkg::COORD_W-1:0];
      epib_pkg::REG_PHI_SCALE: grid_cfg.phi_scale       = data[epib_pkg::COORD_W-1:0];
      epib_pkg::REG_THRESHOLD: grid_cfg.count_threshold = data[epib_pkg::VAL_W-1:0];
      default: ;  // indexes past the register list are dropped
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // result checking, one transaction per accepted result
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [epib_pkg::SUM_W-1:0] want,
                             input logic [epib_pkg::SUM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input epib_pkg::out_item_t got);
    epib_pkg::out_item_t want;
    if (pending_reads.size() == 0) begin
      $error("bin result with no read pending");
      error_count++;
      return;
    end
    want = pending_reads.pop_front();
    check_field("track_sum", want.track_sum, got.track_sum);
    check_field("em_sum", want.em_sum, got.em_sum);
    check_field("had_sum", want.had_sum, got.had_sum);
    check_field("track_count", want.track_count, got.track_count);
    check_field("em_count", want.em_count, got.em_count);
    check_field("had_count", want.had_count, got.had_count);
  endtask

  // result side: sample at the edge, then pick ready for the next cycle;
  // a hold request from the test stalls the output for a counted stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------

  // valid stays high across back-to-back items; stop_sending drops it
  task automatic send_item(input epib_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [epib_pkg::CFG_IDX_W-1:0] idx,
                           input logic [epib_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    update_regs(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits of the 16 bit registers carry noise, they must be ignored
  task automatic set_config(input epib_pkg::cfg_regs_t c);
    write_reg(epib_pkg::REG_ETA_LOW, {8'($urandom), c.eta_low});
    write_reg(epib_pkg::REG_ETA_SCALE, {8'($urandom), c.eta_scale});
    write_reg(epib_pkg::REG_PHI_LOW, {8'($urandom), c.phi_low});
    write_reg(epib_pkg::REG_PHI_SCALE, {8'($urandom), c.phi_scale});
    write_reg(epib_pkg::REG_THRESHOLD, c.count_threshold);
  endtask

  task automatic wait_drain();
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // fills and clears give no result, so let a full clear sweep pass as well
  task automatic settle_for_config();
    wait_drain();
    repeat (CLEAR_PAUSE) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------

  // every field random, the caller sets what matters for the op
  function automatic epib_pkg::in_item_t noise_item(input epib_pkg::op_t op);
    epib_pkg::in_item_t it;
    it.op         = op;
    it.eta        = 16'($urandom);
    it.phi        = 16'($urandom);
    it.track_pt   = 24'($urandom);
    it.em_energy  = 24'($urandom);
    it.had_energy = 24'($urandom);
    it.bin_index  = 12'($urandom);
    return it;
  endfunction

  task automatic send_track(input logic signed [epib_pkg::COORD_W-1:0] eta,
                            input logic signed [epib_pkg::COORD_W-1:0] phi,
                            input logic [epib_pkg::VAL_W-1:0] pt);
    epib_pkg::in_item_t it;
    it          = noise_item(epib_pkg::OP_TRACK);
    it.eta      = eta;
    it.phi      = phi;
    it.track_pt = pt;
    send_item(it);
  endtask

  task automatic send_tower(input logic signed [epib_pkg::COORD_W-1:0] eta,
                            input logic signed [epib_pkg::COORD_W-1:0] phi,
                            input logic [epib_pkg::VAL_W-1:0] em,
                            input logic [epib_pkg::VAL_W-1:0] had);
    epib_pkg::in_item_t it;
    it            = noise_item(epib_pkg::OP_TOWER);
    it.eta        = eta;
    it.phi        = phi;
    it.em_energy  = em;
    it.had_energy = had;
    send_item(it);
  endtask

  task automatic send_read(input logic [epib_pkg::BIN_IDX_W-1:0] idx);
    epib_pkg::in_item_t it;
    it           = noise_item(epib_pkg::OP_READ);
    it.bin_index = idx;
    send_item(it);
  endtask

  // mostly a coordinate inside the grid for the given edge and scale
  function automatic logic signed [epib_pkg::COORD_W-1:0] pick_coord(
      input logic signed [epib_pkg::COORD_W-1:0] low,
      input logic [epib_pkg::COORD_W-1:0] scale);
    int unsigned span;
    if ($urandom_range(4) == 0) return 16'($urandom);
    span = (scale == 0) ? 65535 : ((64 << 20) - 1) / scale;
    if (span > 65535) span = 65535;
    return 16'(low + $urandom_range(span));
  endfunction

  function automatic void refresh_hot_list();
    for (int k = 0; k < HOT_SPOTS; k++) begin
      hot_eta[k] = pick_coord(grid_cfg.eta_low, grid_cfg.eta_scale);
      hot_phi[k] = pick_coord(grid_cfg.phi_low, grid_cfg.phi_scale);
    end
  endfunction

  // reads aim mostly at bins the hot coordinates fill
  function automatic logic [epib_pkg::BIN_IDX_W-1:0] random_read_index();
    int k;
    int idx;
    k = $urandom_range(HOT_SPOTS - 1);
    if ($urandom_range(9) < 7 && locate_bin(hot_eta[k], hot_phi[k], idx)) begin
      return epib_pkg::BIN_IDX_W'(idx);
    end
    return 12'($urandom);
  endfunction

  function automatic logic [epib_pkg::VAL_W-1:0] random_energy();
    case ($urandom_range(9))
      0: return grid_cfg.count_threshold;
      1: return grid_cfg.count_threshold + 1'b1;
      2: return '0;
      3: return {epib_pkg::VAL_W{1'b1}};
      4, 5: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic epib_pkg::in_item_t next_random_item();
    epib_pkg::in_item_t it;
    int r;
    int k;
    r = $urandom_range(999);
    if (r < 2) return noise_item(epib_pkg::OP_CLEAR);
    if (r >= 800) begin
      it           = noise_item(epib_pkg::OP_READ);
      it.bin_index = random_read_index();
      return it;
    end
    it = noise_item((r < 450) ? epib_pkg::OP_TRACK : epib_pkg::OP_TOWER);
    if ($urandom_range(3) != 0) begin
      k      = $urandom_range(HOT_SPOTS - 1);
      it.eta = hot_eta[k];
      it.phi = hot_phi[k];
    end else begin
      it.eta = pick_coord(grid_cfg.eta_low, grid_cfg.eta_scale);
      it.phi = pick_coord(grid_cfg.phi_low, grid_cfg.phi_scale);
    end
    case ($urandom_range(9))
      0: it.track_pt = '0;
      1: it.track_pt = {epib_pkg::VAL_W{1'b1}};
      2, 3: it.track_pt = 24'($urandom_range(255));
      default: ;
    endcase
    it.em_energy  = random_energy();
    it.had_energy = random_energy();
    return it;
  endfunction

  function automatic epib_pkg::cfg_regs_t random_setting();
    epib_pkg::cfg_regs_t c;
    c = epib_pkg::CFG_RESET;
    case ($urandom_range(4))
      0: begin
        c.count_threshold = 24'($urandom_range(3000));
      end
      1: begin
        c.eta_low         = -16'($urandom_range(16384));
        c.eta_scale       = 16'($urandom_range(1000, 8000));
        c.phi_low         = -16'($urandom_range(16384));
        c.phi_scale       = 16'($urandom_range(1000, 8000));
        c.count_threshold = 24'($urandom_range(2000));
      end
      2: begin
        c.eta_low         = 16'($urandom);
        c.eta_scale       = 16'($urandom);
        c.phi_low         = 16'($urandom);
        c.phi_scale       = 16'($urandom);
        c.count_threshold = 24'($urandom);
      end
      3: begin
        // lowest edges, finest grid, nothing counted
        c.eta_low         = 16'sh8000;
        c.eta_scale       = 16'hFFFF;
        c.phi_low         = 16'sh8000;
        c.phi_scale       = 16'hFFFF;
        c.count_threshold = {epib_pkg::VAL_W{1'b1}};
      end
      default: begin
        // highest edges, zero scale: every coordinate lands in bin 0
        c.eta_low         = 16'sh7FFF;
        c.eta_scale       = '0;
        c.phi_low         = 16'sh7FFF;
        c.phi_scale       = '0;
        c.count_threshold = '0;
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // images come out of reset zeroed, read the top bin index
  task automatic test_reset_state();
    send_read({epib_pkg::BIN_IDX_W{1'b1}});
    stop_sending();
  endtask

  // first and last bin on both axes, one step past each edge, field extremes
  task automatic test_grid_edges();
    send_track(-16'sd12288, -16'sd12868, 24'd1);
    send_track(16'sd12285, 16'sd12863, {epib_pkg::VAL_W{1'b1}});
    send_track(-16'sd12289, 16'sd0, 24'd5);
    send_track(16'sd12286, 16'sd0, 24'd5);
    send_track(16'sd0, -16'sd12869, 24'd5);
    send_track(16'sd0, 16'sd12864, 24'd5);
    send_track(16'sh8000, 16'sh7FFF, 24'd7);
    send_track(16'sh7FFF, 16'sh8000, 24'd7);
    send_read('0);
    send_read({epib_pkg::BIN_IDX_W{1'b1}});
    stop_sending();
  endtask

  // energy equal to the threshold is not counted, one above is, zero adds zero
  task automatic test_tower_threshold();
    epib_pkg::cfg_regs_t c;
    settle_for_config();
    c                 = epib_pkg::CFG_RESET;
    c.count_threshold = 24'd1000;
    set_config(c);
    send_tower(-16'sd12288, -16'sd12868, 24'd1000, 24'd1001);
    send_tower(-16'sd12288, -16'sd12868, 24'd0, {epib_pkg::VAL_W{1'b1}});
    send_read('0);
    stop_sending();
    settle_for_config();
    set_config(epib_pkg::CFG_RESET);
    send_tower(-16'sd12288, -16'sd12868, 24'd0, 24'd1);
    send_read('0);
    stop_sending();
  endtask

  task automatic test_clear();
    send_item(noise_item(epib_pkg::OP_CLEAR));
    send_read('0);
    send_read({epib_pkg::BIN_IDX_W{1'b1}});
    stop_sending();
  endtask

  // extreme edges and scales, then writes to indexes past the register list
  task automatic test_register_extremes();
    epib_pkg::cfg_regs_t c;
    settle_for_config();
    c.eta_low         = 16'sh8000;
    c.eta_scale       = 16'hFFFF;
    c.phi_low         = 16'sh7FFF;
    c.phi_scale       = '0;
    c.count_threshold = {epib_pkg::VAL_W{1'b1}};
    set_config(c);
    send_track(16'sh8000, 16'($urandom), 24'd11);
    send_track(-16'sd31744, 16'sh8000, 24'd13);
    send_tower(16'sd0, 16'sh7FFF, {epib_pkg::VAL_W{1'b1}}, 24'd17);
    send_read(12'd63);
    stop_sending();
    settle_for_config();
    c.eta_low         = 16'sh7FFF;
    c.eta_scale       = '0;
    c.phi_low         = 16'sh8000;
    c.phi_scale       = 16'hFFFF;
    c.count_threshold = '0;
    set_config(c);
    for (int i = REG_COUNT; i < (1 << epib_pkg::CFG_IDX_W); i++) begin
      write_reg(epib_pkg::CFG_IDX_W'(i), 24'($urandom));
    end
    send_track(16'sh7FFF, 16'sh8000, 24'd19);
    send_read('0);
    stop_sending();
  endtask

  // two register settings per call, hot coordinates renewed with each
  task automatic test_random_traffic(input int n);
    for (int chunk = 0; chunk < 2; chunk++) begin
      settle_for_config();
      set_config(random_setting());
      refresh_hot_list();
      for (int i = 0; i < n / 2; i++) send_item(next_random_item());
      stop_sending();
    end
  endtask

  // output held off while reads keep coming, then the input waits for all
  task automatic test_backpressure();
    @(negedge clk);
    hold_request = HOLD_OFF_CYCLES;
    @(posedge clk);
    for (int i = 0; i < 12; i++) send_read(random_read_index());
    stop_sending();
    wait_drain();
  endtask

  // track and tower sums run into 0xFFFFFFFF from a cleared image
  task automatic test_saturation();
    int idx;
    settle_for_config();
    set_config(epib_pkg::CFG_RESET);
    send_item(noise_item(epib_pkg::OP_CLEAR));
    void'(locate_bin(-16'sd12288, -16'sd12868, idx));
    for (int i = 1; i <= SAT_FILLS; i++) begin
      send_track(-16'sd12288, -16'sd12868, {epib_pkg::VAL_W{1'b1}});
      if (i % 32 == 0 || i == 256 || i == 257 || i == SAT_FILLS) begin
        send_read(epib_pkg::BIN_IDX_W'(idx));
      end
    end
    void'(locate_bin(16'sd0, 16'sd0, idx));
    for (int i = 1; i <= SAT_FILLS; i++) begin
      send_tower(16'sd0, 16'sd0, {epib_pkg::VAL_W{1'b1}}, {epib_pkg::VAL_W{1'b1}});
      if (i % 32 == 0 || i == 256 || i == 257 || i == SAT_FILLS) begin
        send_read(epib_pkg::BIN_IDX_W'(idx));
      end
    end
    stop_sending();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    clear_image();
    set_idling(17, 72);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_grid_edges();
    test_tower_threshold();
    test_clear();
    test_register_extremes();
    test_random_traffic(RANDOM_ITEMS);
    test_backpressure();

    set_idling(72, 17);
    test_random_traffic(RANDOM_ITEMS);

    set_idling(0, 0);
    test_random_traffic(RANDOM_ITEMS);
    test_saturation();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/epib_pkg.sv
hdl/epib_ram.sv
hdl/epib_locate.sv
hdl/eta_phi_image_binner.sv
test/testbench.sv
